// File: hdl/u8d_pkg.sv
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int CP_WIDTH    = 21;
    localparam int QUEUE_DEPTH = 3;
    localparam int QCOUNT_W    = 2;

    localparam logic [CP_WIDTH-1:0] MIN_LEN1 = 21'h00080;
    localparam logic [CP_WIDTH-1:0] MIN_LEN2 = 21'h00800;
    localparam logic [CP_WIDTH-1:0] MIN_LEN3 = 21'h10000;
    localparam logic [CP_WIDTH-1:0] MAX_LEN1 = 21'h007FF;
    localparam logic [CP_WIDTH-1:0] MAX_LEN2 = 21'h0FFFF;
    localparam logic [CP_WIDTH-1:0] MAX_LEN3 = 21'h10FFFF;

    // One decoded result as it sits in the output queue.
    typedef struct packed {
        logic [CP_WIDTH-1:0] code_point;
        logic                is_error;
        logic                last_of_run;
    } result_t;

    // Sequence state carried from one byte to the next.
    typedef struct packed {
        logic [CP_WIDTH-1:0] partial_value;
        logic [1:0]          bytes_remaining;
        logic [1:0]          sequence_length;
    } seq_state_t;

    // What one byte produces: up to two results, packed from the first slot.
    typedef struct packed {
        logic       push0;
        logic       push1;
        result_t    res0;
        result_t    res1;
        seq_state_t state_next;
    } decode_out_t;

    // Status of the output queue seen by the top level.
    typedef struct packed {
        logic                count_high;
        logic                not_empty;
    } queue_status_t;

endpackage

// File: hdl/u8d_decode.sv
`timescale 1ns / 1ps

module u8d_decode
    import u8d_pkg::*;
(
    input  logic [7:0]  in_byte,
    input  seq_state_t  state,
    output decode_out_t dec
);

    logic                is_cont;
    logic [CP_WIDTH-1:0] acc;
    logic [1:0]          rem_dec;
    logic                range_bad;
    logic                start_emit;
    logic                start_err;
    seq_state_t          start_state;
    seq_state_t          base_state;
    logic                first_emit;
    logic                first_err;
    logic [CP_WIDTH-1:0] first_cp;
    logic                second_emit;
    seq_state_t          nxt_state;

    assign is_cont = (in_byte[7:6] == 2'b10);
    assign acc     = {state.partial_value[CP_WIDTH-7:0], in_byte[5:0]};
    assign rem_dec = state.bytes_remaining - 2'd1;

    always_comb
    begin
        case (state.sequence_length)
            2'd1:    range_bad = (acc < MIN_LEN1) || (acc > MAX_LEN1);
            2'd2:    range_bad = (acc < MIN_LEN2) || (acc > MAX_LEN2);
            2'd3:    range_bad = (acc < MIN_LEN3) || (acc > MAX_LEN3);
            default: range_bad = 1'b1;
        endcase
    end

    // A sequence that is interrupted restarts from a cleared state; otherwise
    // the idle state (already zero) is kept.
    always_comb
    begin
        if (state.bytes_remaining != 2'd0)
        begin
            base_state = '0;
        end
        else
        begin
            base_state = state;
        end
    end

    // Decoding of a byte that starts afresh: with no sequence open, or after an interrupted one.
    always_comb
    begin
        start_emit  = 1'b0;
        start_err   = 1'b0;
        start_state = base_state;
        if (in_byte[7] == 1'b0)
        begin
            start_emit = 1'b1;
        end
        else if (in_byte[7:5] == 3'b110)
        begin
            start_state.partial_value   = {{(CP_WIDTH-5){1'b0}}, in_byte[4:0]};
            start_state.bytes_remaining = 2'd1;
            start_state.sequence_length = 2'd1;
        end
        else if (in_byte[7:4] == 4'b1110)
        begin
            start_state.partial_value   = {{(CP_WIDTH-4){1'b0}}, in_byte[3:0]};
            start_state.bytes_remaining = 2'd2;
            start_state.sequence_length = 2'd2;
        end
        else if (in_byte[7:3] == 5'b11110)
        begin
            start_state.partial_value   = {{(CP_WIDTH-3){1'b0}}, in_byte[2:0]};
            start_state.bytes_remaining = 2'd3;
            start_state.sequence_length = 2'd3;
        end
        else
        begin
            start_emit = 1'b1;
            start_err  = 1'b1;
        end
    end

    always_comb
    begin
        first_emit  = 1'b0;
        first_err   = 1'b0;
        first_cp    = '0;
        second_emit = 1'b0;
        nxt_state   = state;
        if (state.bytes_remaining != 2'd0)
        begin
            if (is_cont)
            begin
                if (rem_dec == 2'd0)
                begin
                    first_emit = 1'b1;
                    first_err  = range_bad;
                    first_cp   = range_bad ? '0 : acc;
                    nxt_state  = '0;
                end
                else
                begin
                    nxt_state.partial_value   = acc;
                    nxt_state.bytes_remaining = rem_dec;
                end
            end
            else
            begin
                // The open sequence is dropped with an error, then the byte
                // is taken again as the start of something new.
                first_emit  = 1'b1;
                first_err   = 1'b1;
                second_emit = start_emit;
                nxt_state   = start_state;
            end
        end
        else
        begin
            first_emit = start_emit;
            first_err  = start_err;
            first_cp   = start_err ? '0 : {{(CP_WIDTH-8){1'b0}}, in_byte};
            nxt_state  = start_state;
        end
    end

    always_comb
    begin
        dec.push0                = first_emit;
        dec.push1                = second_emit;
        dec.res0.code_point      = first_cp;
        dec.res0.is_error        = first_err;
        dec.res0.last_of_run     = !second_emit;
        dec.res1.code_point      = start_err ? '0 : {{(CP_WIDTH-8){1'b0}}, in_byte};
        dec.res1.is_error        = start_err;
        dec.res1.last_of_run     = 1'b1;
        dec.state_next           = nxt_state;
    end

endmodule

// File: hdl/u8d_result_queue.sv
`timescale 1ns / 1ps

module u8d_result_queue
    import u8d_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push0,
    input  logic          push1,
    input  result_t       din0,
    input  result_t       din1,
    input  logic          pop,
    output result_t       head,
    output queue_status_t status
);

    result_t             slot_reg [QUEUE_DEPTH];
    result_t             slot_next [QUEUE_DEPTH];
    logic [QCOUNT_W-1:0] count_reg;
    logic [QCOUNT_W-1:0] count_next;
    logic [QCOUNT_W-1:0] base;

    // Slot zero is always the head; a pop shifts the rest down one place.
    assign base = count_reg - {{(QCOUNT_W-1){1'b0}}, pop};

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && (i < QUEUE_DEPTH - 1))
            begin
                slot_next[i] = slot_reg[i+1];
            end
            else
            begin
                slot_next[i] = slot_reg[i];
            end
            if (push0 && (base == QCOUNT_W'(i)))
            begin
                slot_next[i] = din0;
            end
            if (push1 && ((base + 2'd1) == QCOUNT_W'(i)))
            begin
                slot_next[i] = din1;
            end
        end
    end

    assign count_next = base + {{(QCOUNT_W-1){1'b0}}, push0}
                             + {{(QCOUNT_W-1){1'b0}}, push1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    assign head              = slot_reg[0];
    assign status.not_empty  = (count_reg != '0);
    assign status.count_high = (count_reg > 2'd1);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + {2'b0, push0} + {2'b0, push1} - {2'b0, pop}) <= 3'd3)
        else $error("result queue overflow");

    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push1 |-> push0)
        else $error("second result pushed without a first");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("result queue popped while empty");

endmodule

// File: hdl/utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps

// Streaming UTF-8 decoder.
// The input channel (in_valid, in_stall, in_byte) takes one raw byte per
// beat. The output channel (out_valid, out_stall, code_point, is_error,
// last_of_run) delivers decoded code points, or an error beat with a zero
// code point. last_of_run marks the final result that a byte causes; a byte
// that only opens or extends a sequence causes no result at all.
// A byte is decoded in the cycle it is accepted and its results are written
// into a three-entry result queue whose head drives the output ports.
// Throughput is one byte per cycle while in_stall is low. A byte that
// interrupts an open sequence and is itself ASCII or an invalid lead gives
// two results; the queue then holds at least two entries and in_stall is
// raised while it drains at one beat per cycle when out_stall is low.
// When the receiver stalls, the head result holds on the output ports and
// the queue fills; once it holds two entries in_stall stays high until the
// receiver takes beats again.
// Reset is asynchronous and active low: the sequence state is cleared, the
// queue is emptied and out_valid falls. No result is lost at reset release.
module utf8_stream_decoder_unit
    import u8d_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          in_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CP_WIDTH-1:0] code_point,
    output logic                is_error,
    output logic                last_of_run
);

    seq_state_t    state_reg;
    seq_state_t    state_next;
    decode_out_t   dec;
    result_t       head;
    queue_status_t qstat;
    logic          in_accept;
    logic          out_accept;

    // The stall decision looks only at the queue fill, so it never waits on
    // the receiver's stall in the same cycle.
    assign in_stall   = qstat.count_high;
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = qstat.not_empty;
    assign out_accept = out_valid && !out_stall;

    u8d_decode u_decode (
        .in_byte (in_byte),
        .state   (state_reg),
        .dec     (dec)
    );

    // The sequence state advances only on an accepted beat.
    assign state_next = in_accept ? dec.state_next : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    u8d_result_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push0  (in_accept && dec.push0),
        .push1  (in_accept && dec.push1),
        .din0   (dec.res0),
        .din1   (dec.res1),
        .pop    (out_accept),
        .head   (head),
        .status (qstat)
    );

    assign code_point  = head.code_point;
    assign is_error    = head.is_error;
    assign last_of_run = head.last_of_run;

    // With no sequence open the accumulator and the length are always clear.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.bytes_remaining == 2'd0) |->
        ((state_reg.partial_value == '0) && (state_reg.sequence_length == 2'd0)))
        else $error("idle decoder holds stale sequence state");

    a_remaining_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.bytes_remaining != 2'd0) |->
        (state_reg.bytes_remaining <= state_reg.sequence_length))
        else $error("more continuation bytes expected than the sequence has");

    a_stall_follows_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && dec.push1) |=> in_stall)
        else $error("two results queued without stalling the input");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import u8d_pkg::*;

    // Keeps its own copy of the sequence state, works out the results that
    // each accepted byte must cause and compares delivered beats against them.
    class utf8_checker;
        result_t             expected_points[$];
        logic [CP_WIDTH-1:0] acc;
        logic [1:0]          left;
        logic [1:0]          span;
        int                  mismatches;

        function new();
            acc        = '0;
            left       = 2'd0;
            span       = 2'd0;
            mismatches = 0;
        endfunction

        function void note_byte(logic [7:0] b);
            result_t batch[$];
            result_t r;
            logic    restart;
            logic    bad;
            restart = 1'b1;
            r       = '0;
            if (left != 2'd0) begin
                if (b[7:6] == 2'b10) begin
                    restart = 1'b0;
                    acc     = {acc[CP_WIDTH-7:0], b[5:0]};
                    left    = left - 2'd1;
                    if (left == 2'd0) begin
                        // Overlong and out-of-range values are rejected by length.
                        case (span)
                            2'd1:    bad = (acc < 21'h00080) || (acc > 21'h007FF);
                            2'd2:    bad = (acc < 21'h00800) || (acc > 21'h0FFFF);
                            2'd3:    bad = (acc < 21'h10000) || (acc > 21'h10FFFF);
                            default: bad = 1'b1;
                        endcase
                        r.code_point = bad ? '0 : acc;
                        r.is_error   = bad;
                        batch.push_back(r);
                        acc  = '0;
                        span = 2'd0;
                    end
                end else begin
                    // The open sequence is dropped and the byte starts afresh.
                    r.is_error = 1'b1;
                    batch.push_back(r);
                    acc  = '0;
                    left = 2'd0;
                    span = 2'd0;
                end
            end
            if (restart) begin
                r = '0;
                casez (b)
                    8'b0???????: begin
                        r.code_point = {13'd0, b};
                        batch.push_back(r);
                    end
                    8'b110?????: begin
                        acc  = {16'd0, b[4:0]};
                        left = 2'd1;
                        span = 2'd1;
                    end
                    8'b1110????: begin
                        acc  = {17'd0, b[3:0]};
                        left = 2'd2;
                        span = 2'd2;
                    end
                    8'b11110???: begin
                        acc  = {18'd0, b[2:0]};
                        left = 2'd3;
                        span = 2'd3;
                    end
                    default: begin
                        // Stray continuation or a lead from F8 upwards.
                        r.is_error = 1'b1;
                        batch.push_back(r);
                    end
                endcase
            end
            if (batch.size() != 0) begin
                r = batch.pop_back();
                r.last_of_run = 1'b1;
                batch.push_back(r);
            end
            foreach (batch[i]) expected_points.push_back(batch[i]);
        endfunction

        function void check_result(logic [CP_WIDTH-1:0] cp, logic err, logic last);
            result_t want;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: code_point=%h is_error=%b last_of_run=%b",
                             cp, err, last);
                return;
            end
            want = expected_points.pop_front();
            if (want.code_point !== cp || want.is_error !== err || want.last_of_run !== last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected cp=%h err=%b last=%b, got cp=%h err=%b last=%b",
                             want.code_point, want.is_error, want.last_of_run, cp, err, last);
            end
        endfunction
    endclass

    localparam logic [7:0] DIRECTED [27] = '{
        8'h00, 8'h7F,                   // ASCII extremes, zero included
        8'hC2, 8'h80,                   // smallest two-byte value
        8'hC0, 8'hAF,                   // overlong two-byte form
        8'hED, 8'hA0, 8'h80,            // surrogate passes through
        8'hF4, 8'h8F, 8'hBF, 8'hBF,     // largest legal code point
        8'hF4, 8'h90, 8'h80, 8'h80,     // just above the legal range
        8'h80,                          // stray continuation
        8'hF8, 8'hFF,                   // invalid leads
        8'hC3, 8'h41,                   // sequence cut short by ASCII
        8'hE2, 8'hFE,                   // sequence cut short by an invalid lead
        8'hF0, 8'hC3, 8'hA9             // sequence cut short by a new lead
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          in_byte = 8'h00;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [CP_WIDTH-1:0] code_point;
    logic                is_error;
    logic                last_of_run;

    bit                  no_idle = 1'b0;
    utf8_checker         sb = new();

    utf8_stream_decoder_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .is_error    (is_error),
        .last_of_run (last_of_run)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_wait();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    // Offers one byte after a random gap and returns in the step of acceptance.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (in_stall);
    endtask

    // Both monitors sample the values that stood before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_byte(in_byte);
            if (out_valid && !out_stall)
                sb.check_result(code_point, is_error, last_of_run);
        end
    end

    // Receiver: holds off each beat for a random number of cycles.
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = pick_wait();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        logic [7:0]          burst[$];
        logic [CP_WIDTH-1:0] cp;
        int unsigned         lo;
        int unsigned         hi;
        int                  len;
        int                  kind;
        int                  sent;
        int                  seq_count;
        sent      = 0;
        seq_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i]) send_byte(DIRECTED[i]);

        while (sent < 1700)
        begin
            if (seq_count % 40 == 0)
                no_idle = ($urandom_range(0, 4) == 0);
            seq_count++;
            burst.delete();
            kind = $urandom_range(0, 99);
            len  = $urandom_range(1, 4);
            if (kind < 60)
            begin
                // Well-formed character, sometimes at the edge of its length.
                case (len)
                    1:       begin lo = 32'h0;     hi = 32'h7F;     end
                    2:       begin lo = 32'h80;    hi = 32'h7FF;    end
                    3:       begin lo = 32'h800;   hi = 32'hFFFF;   end
                    default: begin lo = 32'h10000; hi = 32'h10FFFF; end
                endcase
                if ($urandom_range(0, 9) == 0)
                    cp = $urandom_range(0, 1) ? lo[CP_WIDTH-1:0] : hi[CP_WIDTH-1:0];
                else
                    cp = CP_WIDTH'($urandom_range(hi, lo));
                case (len)
                    1: burst.push_back(cp[7:0]);
                    2: begin
                        burst.push_back({3'b110, cp[10:6]});
                        burst.push_back({2'b10, cp[5:0]});
                    end
                    3: begin
                        burst.push_back({4'b1110, cp[15:12]});
                        burst.push_back({2'b10, cp[11:6]});
                        burst.push_back({2'b10, cp[5:0]});
                    end
                    default: begin
                        burst.push_back({5'b11110, cp[20:18]});
                        burst.push_back({2'b10, cp[17:12]});
                        burst.push_back({2'b10, cp[11:6]});
                        burst.push_back({2'b10, cp[5:0]});
                    end
                endcase
            end
            else if (kind < 90)
            begin
                // Any lead with random payload: overlong and out-of-range forms
                // come up here. A third of them are cut short.
                if (len == 1)
                    len = 2;
                case (len)
                    2:       burst.push_back({3'b110, 5'($urandom)});
                    3:       burst.push_back({4'b1110, 4'($urandom)});
                    default: burst.push_back({5'b11110, 3'($urandom)});
                endcase
                if (kind >= 80)
                    len = $urandom_range(1, len - 1);
                repeat (len - 1) burst.push_back({2'b10, 6'($urandom)});
            end
            else
                burst.push_back(8'($urandom_range(0, 255)));
            foreach (burst[i])
            begin
                send_byte(burst[i]);
                sent++;
            end
        end
        in_valid <= 1'b0;
        no_idle   = 1'b1;

        while (sb.expected_points.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_points.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule
